FILE: design/dfq_pkg.sv
// Package for the delimited field quoter.
// Holds the channel word types, the parser mode enum, character codes and
// the queue sizing; imported by the front, queue, back and checker modules.
package dfq_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_item_t;

	typedef enum logic [1:0] {
		MODE_SCAN   = 2'd0,
		MODE_QUOTED = 2'd1,
		MODE_DELIM  = 2'd2,
		MODE_UNQ    = 2'd3
	} mode_t;

	// Output plan for one accepted word: one or two bytes.
	typedef struct packed {
		logic [7:0] first_byte;
		logic [7:0] second_byte;
		logic       two;
	} plan_t;

	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_DASH    = 8'h2D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_TAB     = 8'h09;

	localparam logic [7:0] DELIM_RESET = 8'd44;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

endpackage

FILE: design/dfq_front.sv
// Front end of the delimited field quoter: parser mode machine and
// delimiter register; turns each input word into a one- or two-byte plan, or none for an end mark in scan mode.
// Depends on dfq_pkg.
module dfq_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              delimiter_we,
	input  logic [7:0]        delimiter_wdata,
	input  logic              accept,
	input  dfq_pkg::in_item_t word,
	output logic              push,
	output dfq_pkg::plan_t    plan
);
	import dfq_pkg::*;

	mode_t      mode_q;
	mode_t      mode_d;
	logic [7:0] delimiter_q;
	logic [7:0] c;
	logic       has_out;
	logic       is_ws;
	logic       is_delim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delimiter_q <= DELIM_RESET;
		end else if (delimiter_we) begin
			delimiter_q <= delimiter_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SCAN;
		end else if (accept) begin
			mode_q <= mode_d;
		end
	end

	always_comb begin
		c        = word.in_byte;
		is_ws    = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE);
		is_delim = (c == delimiter_q);
		mode_d   = mode_q;
		has_out  = 1'b1;
		plan     = '{first_byte: CH_QUOTE, second_byte: c, two: 1'b0};
		if (word.end_of_input) begin
			mode_d = MODE_SCAN;
			unique case (mode_q)
				MODE_SCAN:   has_out = 1'b0;
				MODE_QUOTED: plan.first_byte = CH_QUOTE;
				MODE_DELIM:  plan.first_byte = CH_NEWLINE;
				MODE_UNQ: begin
					plan.second_byte = CH_NEWLINE;
					plan.two         = 1'b1;
				end
				default:     has_out = 1'b0;
			endcase
		end else begin
			unique case (mode_q)
				MODE_SCAN: begin
					priority if (c == CH_QUOTE) begin
						mode_d = MODE_QUOTED;
					end else if (is_ws) begin
						plan.first_byte = c;
					end else if (is_delim) begin
						plan.first_byte = CH_SPACE;
						mode_d          = MODE_DELIM;
					end else begin
						plan.two = 1'b1;
						mode_d   = MODE_UNQ;
					end
				end
				MODE_QUOTED: begin
					if (c == CH_QUOTE) begin
						mode_d = MODE_SCAN;
					end else begin
						plan.first_byte = c;
					end
				end
				MODE_DELIM: begin
					priority if (c == CH_QUOTE) begin
						mode_d = MODE_QUOTED;
					end else if (c == CH_NEWLINE) begin
						plan.first_byte = CH_NEWLINE;
						mode_d          = MODE_SCAN;
					end else if (is_delim) begin
						plan.first_byte  = CH_DASH;
						plan.second_byte = CH_SPACE;
						plan.two         = 1'b1;
					end else begin
						plan.two = 1'b1;
						mode_d   = MODE_UNQ;
					end
				end
				MODE_UNQ: begin
					priority if (c == CH_NEWLINE) begin
						plan.second_byte = CH_NEWLINE;
						plan.two         = 1'b1;
						mode_d           = MODE_SCAN;
					end else if (c == CH_QUOTE) begin
						plan.second_byte = CH_QUOTE;
						plan.two         = 1'b1;
					end else if (is_delim) begin
						plan.second_byte = CH_SPACE;
						plan.two         = 1'b1;
						mode_d           = MODE_DELIM;
					end else begin
						plan.first_byte = c;
					end
				end
				default: has_out = 1'b0;
			endcase
		end
		push = accept && has_out;
	end

endmodule

FILE: design/dfq_queue.sv
// Short plan queue between the front and back of the quoter.
// Depends on dfq_pkg.
module dfq_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dfq_pkg::plan_t push_plan,
	input  logic           pop,
	output logic           full,
	output logic           nempty,
	output dfq_pkg::plan_t head
);
	import dfq_pkg::*;

	plan_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full   = (count_q == QCNT_W'(QDEPTH));
	assign nempty = (count_q != '0);
	assign head   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_plan;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: design/dfq_back.sv
// Back end of the quoter: serializes each queued plan into output words
// through one output register. Depends on dfq_pkg.
module dfq_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               nempty,
	input  dfq_pkg::plan_t     head,
	output logic               pop,
	input  logic               dst_stall,
	output logic               dst_valid,
	output dfq_pkg::out_item_t dst_word
);
	import dfq_pkg::*;

	logic      out_valid_q;
	out_item_t out_word_q;
	logic      phase_q;
	logic      load;

	assign load      = nempty && (!out_valid_q || !dst_stall);
	assign pop       = load && (phase_q || !head.two);
	assign dst_valid = out_valid_q;
	assign dst_word  = out_word_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_word_q.out_byte    <= phase_q ? head.second_byte : head.first_byte;
			out_word_q.last_of_run <= phase_q || !head.two;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				phase_q     <= !phase_q && head.two;
			end else if (!dst_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: design/delimited_field_quoter.sv
// Top level of the delimited field quoter: front parser, plan queue and
// output serializer. Depends on dfq_pkg, dfq_front, dfq_queue, dfq_back.
//
// Source channel (src_valid, src_stall, src_word): one text byte or an
// end-of-input mark per word, taken at an edge with src_valid high and
// src_stall low. Destination channel (dst_valid, dst_stall, dst_word): one
// rewritten byte per word, last_of_run set on the final byte of an input.
// The delimiter register is to be written by delimiter_we / delimiter_wdata
// only while the block is idle; the block does not enforce it. Reset loads a
// comma. With the queue empty, the first output byte of an input passes
// through the plan queue and then the output register before it is offered.
// One input is taken per cycle while each gives at most one byte and dst_stall
// is low; inputs that give two bytes are paced by the single-byte output port.
// An input that gives no byte is taken without entering the queue.
// A two-entry plan queue sits between parser and serializer; src_stall
// rises only when it is full. While dst_stall is high the output word holds.
// Reset clears the parser to scan mode, empties the queue and drops
// dst_valid.
module delimited_field_quoter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               delimiter_we,
	input  logic [7:0]         delimiter_wdata,
	input  logic               src_valid,
	output logic               src_stall,
	input  dfq_pkg::in_item_t  src_word,
	output logic               dst_valid,
	input  logic               dst_stall,
	output dfq_pkg::out_item_t dst_word
);
	import dfq_pkg::*;

	logic  accept;
	logic  push;
	logic  pop;
	logic  full;
	logic  nempty;
	plan_t push_plan;
	plan_t head;

	assign src_stall = full;
	assign accept    = src_valid && !full;

	dfq_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.delimiter_we    (delimiter_we),
		.delimiter_wdata (delimiter_wdata),
		.accept          (accept),
		.word            (src_word),
		.push            (push),
		.plan            (push_plan)
	);

	dfq_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_plan (push_plan),
		.pop       (pop),
		.full      (full),
		.nempty    (nempty),
		.head      (head)
	);

	dfq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.nempty    (nempty),
		.head      (head),
		.pop       (pop),
		.dst_stall (dst_stall),
		.dst_valid (dst_valid),
		.dst_word  (dst_word)
	);

endmodule

FILE: design/dfq_checker.sv
// Port-level checks for the delimited field quoter, bound to the top level.
// Depends on dfq_pkg.
module dfq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               src_valid,
	input logic               src_stall,
	input logic               dst_valid,
	input logic               dst_stall,
	input dfq_pkg::out_item_t dst_word
);
	import dfq_pkg::*;

	a_dst_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> dst_valid)
		else $error("dst_valid dropped while stalled");

	a_dst_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> $stable(dst_word))
		else $error("dst_word changed while stalled");

	a_stall_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(src_stall) |-> $past(src_valid && !src_stall))
		else $error("src_stall rose without an accepted word");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_stall && !dst_word.last_of_run |=> dst_valid)
		else $error("byte run broken after a non-final byte");

endmodule

bind delimited_field_quoter dfq_checker u_dfq_checker (.*);

FILE: verif/testbench.sv
// Self-checking testbench for delimited_field_quoter: drives text bytes and end marks,
// predicts the quoted output stream and checks every output word against it.
// Depends on dfq_pkg and the delimited_field_quoter RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import dfq_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam int HOLD_LEN    = 150;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       delimiter_we = 1'b0;
	logic [7:0] delimiter_wdata = 8'd0;
	logic       src_valid = 1'b0;
	logic       src_stall;
	in_item_t   src_word = '0;
	logic       dst_valid;
	logic       dst_stall = 1'b0;
	out_item_t  dst_word;

	in_item_t   src_pending [$];
	out_item_t  quoted_bytes [$];
	mode_t      field_mode = MODE_SCAN;
	logic [7:0] cur_delim = DELIM_RESET;
	bit         idle_on = 1'b1;
	bit         hold_req = 1'b0;
	bit         hold_seen;
	int         gap_left;
	int         hold_left;
	int         quiet;
	int         errors = 0;
	int         pushed = 0;

	delimited_field_quoter dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.delimiter_we    (delimiter_we),
		.delimiter_wdata (delimiter_wdata),
		.src_valid       (src_valid),
		.src_stall       (src_stall),
		.src_word        (src_word),
		.dst_valid       (dst_valid),
		.dst_stall       (dst_stall),
		.dst_word        (dst_word)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] text_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return 8'($urandom_range(8'h21, 8'h7E));
		if (r == 7)
			return CH_QUOTE;
		return 8'($urandom_range(0, 255));
	endfunction

	// Advance the field parser by one word and queue the bytes it yields.
	task automatic quote_word(input in_item_t w);
		logic [7:0] b [2];
		logic [7:0] c;
		int n;
		n = 0;
		c = w.in_byte;
		if (w.end_of_input) begin
			case (field_mode)
				MODE_QUOTED: begin
					b[n] = CH_QUOTE; n++;
				end
				MODE_DELIM: begin
					b[n] = CH_NEWLINE; n++;
				end
				MODE_UNQ: begin
					b[n] = CH_QUOTE; n++;
					b[n] = CH_NEWLINE; n++;
				end
				default: ;
			endcase
			field_mode = MODE_SCAN;
		end else begin
			case (field_mode)
				MODE_SCAN: begin
					if (c == CH_QUOTE) begin
						b[n] = CH_QUOTE; n++;
						field_mode = MODE_QUOTED;
					end else if (c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE) begin
						b[n] = c; n++;
					end else if (c == cur_delim) begin
						b[n] = CH_SPACE; n++;
						field_mode = MODE_DELIM;
					end else begin
						b[n] = CH_QUOTE; n++;
						b[n] = c; n++;
						field_mode = MODE_UNQ;
					end
				end
				MODE_QUOTED: begin
					b[n] = c; n++;
					if (c == CH_QUOTE)
						field_mode = MODE_SCAN;
				end
				MODE_DELIM: begin
					if (c == CH_QUOTE) begin
						b[n] = CH_QUOTE; n++;
						field_mode = MODE_QUOTED;
					end else if (c == CH_NEWLINE) begin
						b[n] = CH_NEWLINE; n++;
						field_mode = MODE_SCAN;
					end else if (c == cur_delim) begin
						b[n] = CH_DASH; n++;
						b[n] = CH_SPACE; n++;
					end else begin
						b[n] = CH_QUOTE; n++;
						b[n] = c; n++;
						field_mode = MODE_UNQ;
					end
				end
				default: begin
					if (c == CH_NEWLINE) begin
						b[n] = CH_QUOTE; n++;
						b[n] = CH_NEWLINE; n++;
						field_mode = MODE_SCAN;
					end else if (c == CH_QUOTE) begin
						b[n] = CH_QUOTE; n++;
						b[n] = CH_QUOTE; n++;
					end else if (c == cur_delim) begin
						b[n] = CH_QUOTE; n++;
						b[n] = CH_SPACE; n++;
						field_mode = MODE_DELIM;
					end else begin
						b[n] = c; n++;
					end
				end
			endcase
		end
		for (int i = 0; i < n; i++)
			quoted_bytes.push_back('{out_byte: b[i], last_of_run: (i == n - 1)});
	endtask

	// Driver: offer pending words, predict each one as it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
			src_word <= '0;
			gap_left <= 0;
		end else begin
			if (src_valid && !src_stall)
				quote_word(src_word);
			if (!src_valid || !src_stall) begin
				if (gap_left > 0) begin
					src_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (src_pending.size() != 0) begin
					src_word <= src_pending.pop_front();
					src_valid <= 1'b1;
					gap_left <= pick_gap();
				end else begin
					src_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each taken word, drive the receiver stall.
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		int g;
		if (!arst_n) begin
			dst_stall <= 1'b0;
			hold_left <= 0;
			hold_seen <= 1'b0;
		end else begin
			if (dst_valid && !dst_stall) begin
				if (quoted_bytes.size() == 0) begin
					if (errors < 50)
						$error("unexpected word: out_byte %h last_of_run %b",
							dst_word.out_byte, dst_word.last_of_run);
					errors++;
				end else begin
					want = quoted_bytes.pop_front();
					if (want.out_byte !== dst_word.out_byte) begin
						if (errors < 50)
							$error("out_byte: expected %h, got %h",
								want.out_byte, dst_word.out_byte);
						errors++;
					end
					if (want.last_of_run !== dst_word.last_of_run) begin
						if (errors < 50)
							$error("last_of_run: expected %b, got %b",
								want.last_of_run, dst_word.last_of_run);
						errors++;
					end
				end
			end
			if (hold_req && !hold_seen) begin
				hold_seen <= 1'b1;
				dst_stall <= 1'b1;
				hold_left <= HOLD_LEN;
			end else if (hold_left > 0) begin
				dst_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else begin
				g = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
				dst_stall <= (g != 0);
				hold_left <= (g > 0) ? g - 1 : 0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((src_valid && !src_stall) || (dst_valid && !dst_stall)) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("Verification failed");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end else begin
			quiet <= 0;
		end
	end

	task automatic push_byte(input logic [7:0] b);
		src_pending.push_back('{in_byte: b, end_of_input: 1'b0});
		pushed++;
	endtask

	task automatic push_eoi(input logic [7:0] b);
		src_pending.push_back('{in_byte: b, end_of_input: 1'b1});
		pushed++;
	endtask

	// Mostly well-formed records of quoted, bare and empty fields; some noise.
	task automatic push_record();
		int nfields;
		if ($urandom_range(0, 99) < 15) begin
			repeat ($urandom_range(3, 10)) begin
				if ($urandom_range(0, 9) == 0)
					push_eoi(8'($urandom_range(0, 255)));
				else
					push_byte(8'($urandom_range(0, 255)));
			end
		end else begin
			nfields = $urandom_range(1, 5);
			for (int f = 0; f < nfields; f++) begin
				if (f > 0)
					repeat (($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1)
						push_byte(cur_delim);
				case ($urandom_range(0, 3))
					0: begin
						push_byte(CH_QUOTE);
						repeat ($urandom_range(0, 6))
							push_byte(text_byte());
						push_byte(CH_QUOTE);
					end
					1, 2: begin
						repeat ($urandom_range(1, 6))
							push_byte(text_byte());
					end
					default: ;
				endcase
			end
			if ($urandom_range(0, 4) == 0)
				push_eoi(8'($urandom_range(0, 255)));
			else
				push_byte(CH_NEWLINE);
		end
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (src_pending.size() != 0 || src_valid || quoted_bytes.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_delim(input logic [7:0] v);
		@(posedge clk);
		delimiter_we <= 1'b1;
		delimiter_wdata <= v;
		cur_delim = v;
		@(posedge clk);
		delimiter_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		logic [7:0] delims [12];
		delims = '{8'd1, 8'd255, 8'd44, CH_QUOTE, CH_SPACE, CH_TAB, CH_NEWLINE, 8'd0,
			8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)), 8'd59, 8'd255};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset delimiter: every mode against the end mark, the quote and the delimiter
		push_eoi(8'hFF);
		push_byte(CH_SPACE);
		push_byte(CH_TAB);
		push_byte(CH_NEWLINE);
		push_byte(CH_QUOTE);
		push_byte(8'h00);
		push_byte(8'd44);
		push_byte(CH_QUOTE);
		push_byte(8'd44);
		push_byte(8'd44);
		push_byte(CH_QUOTE);
		push_eoi(CH_QUOTE);
		push_byte(8'd44);
		push_byte(CH_NEWLINE);
		push_byte(8'd44);
		push_byte(8'hFF);
		push_byte(CH_QUOTE);
		push_byte(8'd44);
		push_eoi(8'd44);
		push_byte(8'h61);
		push_byte(CH_NEWLINE);
		push_byte(8'h80);
		push_eoi(8'h00);
		drain();

		for (int p = 0; p < 12; p++) begin
			set_delim(delims[p]);
			idle_on = (p % 4 != 2);
			pushed = 0;
			while (pushed < 110)
				push_record();
			if (p == 2)
				hold_req = 1'b1;
			drain();
		end

		if (errors == 0 && quoted_bytes.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: files.f
design/dfq_pkg.sv
design/dfq_front.sv
design/dfq_queue.sv
design/dfq_back.sv
design/delimited_field_quoter.sv
design/dfq_checker.sv
verif/testbench.sv
